FILE: design/nonoverlapping_pattern_matcher_core_macros.svh
// assertion helpers for the pattern matcher checker
`ifndef NONOVERLAPPING_PATTERN_MATCHER_CORE_MACROS_SVH
`define NONOVERLAPPING_PATTERN_MATCHER_CORE_MACROS_SVH

// same-cycle implication, held off while in reset
`define NPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while in reset
`define NPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/npm_pkg.sv
package npm_pkg;

	localparam int MAX_PATTERN_DEF    = 16;
	localparam int POSITION_WIDTH_DEF = 32;

	localparam int BYTE_W      = 8;
	localparam int REG_W       = 64;
	localparam int PATTERN_W   = 2 * REG_W;
	localparam int LEN_W       = 5;
	localparam int MATCH_W     = 32;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = CFG_INDEX_W'(2);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic [LEN_W-1:0]     length_eff;
	} cfg_t;

	typedef struct packed {
		logic               hit;
		logic [MATCH_W-1:0] start;
	} res_t;

endpackage

FILE: design/npm_cfg.sv
module npm_cfg #(
	parameter int MAX_PATTERN = npm_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [npm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [npm_pkg::REG_W-1:0]       cfg_data,
	output npm_pkg::cfg_t                   cfg
);
	import npm_pkg::*;

	logic [REG_W-1:0] pattern_low_q;
	logic [REG_W-1:0] pattern_high_q;
	logic [LEN_W-1:0] length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			length_q       <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				REG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				REG_PATTERN_LEN:  length_q       <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// zero reads as one, anything beyond the window as the full window
	always_comb begin
		cfg.pattern = {pattern_high_q, pattern_low_q};
		if (length_q == '0)
			cfg.length_eff = LEN_W'(1);
		else if (length_q > LEN_W'(MAX_PATTERN))
			cfg.length_eff = LEN_W'(MAX_PATTERN);
		else
			cfg.length_eff = length_q;
	end

endmodule

FILE: design/npm_compare.sv
module npm_compare #(
	parameter int MAX_PATTERN = npm_pkg::MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN-1:0][npm_pkg::BYTE_W-1:0] window,
	input  logic [npm_pkg::PATTERN_W-1:0]               pattern,
	input  logic [npm_pkg::LEN_W-1:0]                   length_eff,
	output logic                                        equal
);
	import npm_pkg::*;

	localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0] miss;

	// pattern byte i lines up with window entry length-1-i, newest at entry 0
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
		logic             active;
		logic [LEN_W-1:0] idx;
		logic [BYTE_W-1:0] win_byte;

		assign active   = LEN_W'(i) < length_eff;
		assign idx      = length_eff - LEN_W'(1) - LEN_W'(i);
		assign win_byte = window[idx[WIN_IDX_W-1:0]];
		assign miss[i]  = active && (win_byte != pattern[BYTE_W*i +: BYTE_W]);
	end

	assign equal = ~|miss;

endmodule

FILE: design/npm_stream.sv
module npm_stream #(
	parameter int MAX_PATTERN    = npm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_WIDTH = npm_pkg::POSITION_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [npm_pkg::BYTE_W-1:0] text_byte_s1,
	input  logic                       end_of_text_s1,
	input  npm_pkg::cfg_t              cfg,
	output npm_pkg::res_t              res
);
	import npm_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int SW    = (POSITION_WIDTH > MATCH_W) ? POSITION_WIDTH : MATCH_W;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_q;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_new;
	logic [POSITION_WIDTH-1:0]          pos_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [CNT_W-1:0]                   cnt_inc;
	logic [LEN_W-1:0]                   len_m1;
	logic [POSITION_WIDTH-1:0]          start_pos;
	logic [SW-1:0]                      start_ext;
	logic                               equal;
	logic                               hit;

	assign window_new[0] = text_byte_s1;
	for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_shift
		assign window_new[j] = window_q[j-1];
	end

	npm_compare #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_compare (
		.window    (window_new),
		.pattern   (cfg.pattern),
		.length_eff(cfg.length_eff),
		.equal     (equal)
	);

	// bytes since the last match, saturating at the window depth
	assign cnt_inc = (cnt_q < CNT_W'(MAX_PATTERN)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign hit     = equal && (LEN_W'(cnt_inc) >= cfg.length_eff);

	assign len_m1    = cfg.length_eff - LEN_W'(1);
	assign start_pos = (pos_q >= POSITION_WIDTH'(len_m1)) ?
	                   pos_q - POSITION_WIDTH'(len_m1) : '0;
	assign start_ext = SW'(start_pos);

	assign res.hit   = hit;
	assign res.start = start_ext[MATCH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
			cnt_q    <= '0;
		end else if (advance) begin
			if (end_of_text_s1) begin
				window_q <= '0;
				pos_q    <= '0;
				cnt_q    <= '0;
			end else begin
				window_q <= window_new;
				if (pos_q != '1)
					pos_q <= pos_q + POSITION_WIDTH'(1);
				cnt_q <= hit ? '0 : cnt_inc;
			end
		end
	end

endmodule

FILE: design/nonoverlapping_pattern_matcher_core.sv
// channel   | handshake                 | payload
// text      | text_valid / text_stall   | text_byte, end_of_text
// match     | match_valid / match_stall | match_start
// cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one byte per cycle while no result is held; a match passes byte then result register
// the byte register feeds the window compare and result register in a single stage
// text_stall rises only while the byte register is full and the result is held
// cfg_ready is always high; writes land at once and apply from the next byte
// asynchronous reset clears the window, position, byte count and pattern length to one
module nonoverlapping_pattern_matcher_core #(
	parameter int MAX_PATTERN    = npm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_WIDTH = npm_pkg::POSITION_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	output logic                            text_stall,
	input  logic [npm_pkg::BYTE_W-1:0]      text_byte,
	input  logic                            end_of_text,
	output logic                            match_valid,
	input  logic                            match_stall,
	output logic [npm_pkg::MATCH_W-1:0]     match_start,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [npm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [npm_pkg::REG_W-1:0]       cfg_data
);
	import npm_pkg::*;

	cfg_t               cfg;
	res_t               res;
	logic               valid_s1;
	logic [BYTE_W-1:0]  text_byte_s1;
	logic               end_of_text_s1;
	logic               match_valid_q;
	logic [MATCH_W-1:0] match_start_q;
	logic               out_free;
	logic               advance;
	logic               text_xfer;

	assign cfg_ready = 1'b1;

	npm_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// result register can take a new value when empty or being drained
	assign out_free   = !match_valid_q || !match_stall;
	assign advance    = valid_s1 && out_free;
	assign text_stall = valid_s1 && !out_free;
	assign text_xfer  = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= text_xfer || (valid_s1 && !advance);
	end

	always_ff @(posedge clk) begin
		if (text_xfer) begin
			text_byte_s1   <= text_byte;
			end_of_text_s1 <= end_of_text;
		end
	end

	npm_stream #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_stream (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.text_byte_s1  (text_byte_s1),
		.end_of_text_s1(end_of_text_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			match_valid_q <= 1'b0;
		else if (out_free)
			match_valid_q <= advance && res.hit;
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit)
			match_start_q <= res.start;
	end

	assign match_valid = match_valid_q;
	assign match_start = match_start_q;

endmodule

FILE: design/npm_checker.sv
`include "nonoverlapping_pattern_matcher_core_macros.svh"

module npm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        text_valid,
	input logic                        text_stall,
	input logic                        match_valid,
	input logic                        match_stall,
	input logic [npm_pkg::MATCH_W-1:0] match_start
);

	// a held result keeps its position
	`NPM_ASSERT_NEXT(a_match_hold, match_valid && match_stall, match_valid && $stable(match_start), "held match changed")

	// input back-pressure only while a result is held downstream
	`NPM_ASSERT_IMP(a_stall_cause, text_stall, match_valid && match_stall, "text stalled with no held match")

	// a fresh result comes from a text byte transferred earlier, through the byte register
	`NPM_ASSERT_IMP(a_match_source, $rose(match_valid), $past(text_valid && !text_stall, 2), "match without a text transfer")

endmodule

bind nonoverlapping_pattern_matcher_core npm_checker u_npm_checker (.*);

FILE: verif/nonoverlapping_pattern_matcher_core_tb.sv
module nonoverlapping_pattern_matcher_core_tb;
	import npm_pkg::*;

	localparam int MAX_PAT = MAX_PATTERN_DEF;
	localparam int POS_W   = POSITION_WIDTH_DEF;
	localparam int LATENCY = 6;
	localparam int LONG_HOLD = 80;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);

	class match_tracker;
		bit [PATTERN_W-1:0] pattern;
		bit [LEN_W-1:0]     length_code;
		bit [BYTE_W-1:0]    window [MAX_PAT];
		bit [POS_W-1:0]     position;
		bit [LEN_W-1:0]     since_match;
		bit [MATCH_W-1:0]   pending_starts [$];
		int                 errors;

		function new();
			pattern     = '0;
			length_code = LEN_RESET;
			errors      = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (window[i]) window[i] = '0;
			position    = '0;
			since_match = '0;
		endfunction

		function void set_reg(bit [CFG_INDEX_W-1:0] idx, bit [REG_W-1:0] data);
			case (idx)
				REG_PATTERN_LOW:  pattern[REG_W-1:0] = data;
				REG_PATTERN_HIGH: pattern[PATTERN_W-1:REG_W] = data;
				REG_PATTERN_LEN:  length_code = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_byte(bit [BYTE_W-1:0] b, bit last);
			int             eff;
			bit             hit;
			bit [POS_W-1:0] start;
			eff = (length_code == 0) ? 1 : (length_code > MAX_PAT) ? MAX_PAT : int'(length_code);
			for (int i = MAX_PAT - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = b;
			if (since_match < MAX_PAT) since_match++;
			if (since_match >= eff) begin
				hit = 1'b1;
				// oldest window byte lines up with pattern byte 0
				for (int i = 0; i < eff; i++)
					if (window[eff-1-i] != pattern[8*i +: 8]) hit = 1'b0;
				if (hit) begin
					start = (position >= POS_W'(eff - 1)) ? position - POS_W'(eff - 1) : '0;
					pending_starts.push_back(MATCH_W'(start));
					since_match = '0;
				end
			end
			if (position != '1) position++;
			if (last) clear_stream();
		endfunction

		function void check_start(bit [MATCH_W-1:0] got);
			bit [MATCH_W-1:0] want;
			if (pending_starts.size() == 0) begin
				errors++;
				$display("%0t: match_start expected none, got %0d", $time, got);
			end else begin
				want = pending_starts.pop_front();
				if (want != got) begin
					errors++;
					$display("%0t: match_start expected %0d, got %0d", $time, want, got);
				end
			end
		endfunction
	endclass

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   text_valid  = 1'b0;
	logic                   text_stall;
	logic [BYTE_W-1:0]      text_byte   = '0;
	logic                   end_of_text = 1'b0;
	logic                   match_valid;
	logic                   match_stall = 1'b0;
	logic [MATCH_W-1:0]     match_start;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [REG_W-1:0]       cfg_data    = '0;

	match_tracker tracker = new();

	int                 send_idle = 0;
	int                 recv_idle = 0;
	bit                 hold_req  = 1'b0;
	bit                 hold_ack  = 1'b0;
	int                 hold_left = 0;
	int                 sent_items = 0;
	bit [PATTERN_W-1:0] cur_pat = '0;
	int                 cur_eff = 1;

	always #5 clk = ~clk;

	nonoverlapping_pattern_matcher_core #(
		.MAX_PATTERN    (MAX_PAT),
		.POSITION_WIDTH (POS_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.match_start (match_start),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// receiver: random stalls, plus a long hold-off whenever one is requested
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack    <= hold_req;
			hold_left   <= LONG_HOLD;
			match_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left   <= hold_left - 1;
			match_stall <= 1'b1;
		end else begin
			match_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
			// a result now belongs to an earlier byte, so check before noting this one
			if (match_valid && !match_stall)
				tracker.check_start(match_start);
			if (text_valid && !text_stall)
				tracker.take_byte(text_byte, end_of_text);
		end
	end

	task automatic write_reg(input bit [CFG_INDEX_W-1:0] idx, input bit [REG_W-1:0] data,
			input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
	endtask

	task automatic load_pattern(input bit [LEN_W-1:0] code, input bit [PATTERN_W-1:0] pat);
		bit [REG_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = code;
		write_reg(REG_PATTERN_LOW, pat[REG_W-1:0], 1'b1);
		write_reg(REG_PATTERN_HIGH, pat[PATTERN_W-1:REG_W], 1'b1);
		write_reg(REG_PATTERN_LEN, len_word, 1'b0);
		cur_pat = pat;
		cur_eff = (code == 0) ? 1 : (code > MAX_PAT) ? MAX_PAT : int'(code);
	endtask

	task automatic send_byte(input bit [BYTE_W-1:0] b, input bit last);
		while ($urandom_range(99) < send_idle) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		end_of_text <= last;
		do @(posedge clk); while (text_stall);
		sent_items++;
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_starts.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// mostly copies of the pattern and its bytes, with some noise
	task automatic send_text(input int n, input bit last);
		int              k;
		int              r;
		int              idx;
		bit [BYTE_W-1:0] b;
		k = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				b = cur_pat[8*k +: 8];
				k = (k + 1) % cur_eff;
			end else if (r < 85) begin
				idx = $urandom_range(cur_eff - 1);
				b = cur_pat[8*idx +: 8];
			end else begin
				b = BYTE_W'($urandom);
			end
			send_byte(b, last && (i == n - 1));
		end
	endtask

	initial begin
		int                 phase_start;
		int                 n;
		int                 r;
		bit [LEN_W-1:0]     code;
		bit [PATTERN_W-1:0] pat;
		bit [BYTE_W-1:0]    c0;
		bit [BYTE_W-1:0]    c1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset pattern is a single zero byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();

		// repeated bytes: matches must not overlap
		load_pattern(5'd3, 128'h616161);
		repeat (5) send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b1);
		wait_drained();

		// length zero behaves as one
		load_pattern(5'd0, 128'hff);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		wait_drained();

		// out-of-range index leaves the pattern alone
		write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b0);
		send_byte(8'hff, 1'b1);
		wait_drained();

		// pattern changed mid-text, window kept
		load_pattern(5'd2, 128'h7978);
		send_byte(8'h78, 1'b0);
		wait_drained();
		load_pattern(5'd2, 128'h7a78);
		send_byte(8'h7a, 1'b1);
		wait_drained();

		// end of text clears the window and position
		load_pattern(5'd2, 128'h6261);
		send_byte(8'h61, 1'b1);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 38;
					recv_idle = 46;
				end
				1: begin
					send_idle = 46;
					recv_idle = 38;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase

			if (ph == 0) begin
				// every byte matches while the receiver holds off, so the block backs up
				load_pattern(5'd1, 128'h41);
				hold_req <= ~hold_req;
				n = send_idle;
				send_idle = 0;
				repeat (29) send_byte(8'h41, 1'b0);
				send_byte(8'h41, 1'b1);
				send_idle = n;
				wait_drained();
			end

			phase_start = sent_items;
			while (sent_items - phase_start < 250) begin
				if ($urandom_range(3) == 0) begin
					wait_drained();
					r = $urandom_range(99);
					if (r < 65)
						code = LEN_W'($urandom_range(1, 6));
					else if (r < 82)
						code = LEN_W'($urandom_range(7, 15));
					else if (r < 92)
						code = 5'd16;
					else if (r < 96)
						code = 5'd0;
					else
						code = LEN_W'($urandom_range(17, 31));
					if ($urandom_range(1)) begin
						pat = {$urandom, $urandom, $urandom, $urandom};
					end else begin
						// two-letter alphabet gives self-overlapping patterns
						c0 = BYTE_W'($urandom);
						c1 = BYTE_W'($urandom);
						for (int i = 0; i < 16; i++)
							pat[8*i +: 8] = $urandom_range(1) ? c0 : c1;
					end
					load_pattern(code, pat);
					if ($urandom_range(4) == 0)
						write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b0);
				end
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 24);
				send_text(n, $urandom_range(9) != 0);
			end
		end

		wait_drained();
		if (tracker.pending_starts.size() != 0) begin
			tracker.errors++;
			$display("%0t: match_start expected %0d, got none (%0d outstanding)", $time,
				tracker.pending_starts[0], tracker.pending_starts.size());
		end
		if (tracker.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
